// ----- src/mtrrl_pkg.sv -----
`default_nettype none

package mtrrl_pkg;

	// Field widths fixed by the interface
	localparam int ENTRY_W = 5;
	localparam int ADDR_W  = 32;
	localparam int WORD_W  = 64;
	localparam int TYPE_W  = 8;
	localparam int PAB_W   = 6;
	localparam int SIZE_W  = 53;
	localparam int BASE_W  = 20;   // base bits 31:12

	// Parameter defaults
	localparam int VAR_RANGES_DEF = 32;
	localparam int FIXED_REGS_DEF = 11;

	// Opcodes
	localparam logic [1:0] OP_LOOKUP    = 2'd0;
	localparam logic [1:0] OP_VAR_WRITE = 2'd1;
	localparam logic [1:0] OP_FIX_WRITE = 2'd2;

	// Memory types and address map
	localparam logic [TYPE_W-1:0] TYPE_WRITEBACK = 8'd6;
	localparam logic [ADDR_W-1:0] ONE_MEG        = 32'h0010_0000;
	localparam logic [ADDR_W-1:0] FIX16_START    = 32'h0008_0000;
	localparam logic [ADDR_W-1:0] FIX16B_START   = 32'h000A_0000;
	localparam logic [ADDR_W-1:0] FIX4_START     = 32'h000C_0000;

	localparam int RANGE_VALID_BIT = 11;
	localparam logic [SIZE_W-1:0] PAGE_OFFSET_MASK = 53'hFFF;

	// Physical address width register
	localparam logic [PAB_W-1:0] PAB_RESET = 6'd36;
	localparam logic [PAB_W-1:0] PAB_MIN   = 6'd32;
	localparam logic [PAB_W-1:0] PAB_MAX   = 6'd52;

	// One beat travelling down the row of range cells
	typedef struct packed {
		logic                lookup;   // lookup beat
		logic                var_wr;   // variable range write beat
		logic [ENTRY_W-1:0]  idx;
		logic [ADDR_W-1:0]   addr;
		logic                hit;      // type already resolved
		logic [TYPE_W-1:0]   mtype;    // resolved type, or type to write
		logic [BASE_W-1:0]   wbase;
		logic [SIZE_W-1:0]   wsize;
	} beat_t;

endpackage

`default_nettype wire

// ----- src/mtrrl_entry.sv -----
`default_nettype none

module mtrrl_entry #(
	parameter int FIXED_REGS = mtrrl_pkg::FIXED_REGS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          in_valid,
	input  wire logic [1:0]                    opcode,
	input  wire logic [mtrrl_pkg::ENTRY_W-1:0] entry_index,
	input  wire logic [mtrrl_pkg::WORD_W-1:0]  base_word,
	input  wire logic [mtrrl_pkg::WORD_W-1:0]  mask_word,
	input  wire logic [mtrrl_pkg::ADDR_W-1:0]  lookup_address,
	input  wire logic [mtrrl_pkg::PAB_W-1:0]   phys_addr_bits,
	output mtrrl_pkg::beat_t                   beat_out
);
	import mtrrl_pkg::*;

	localparam int FIX_IW = $clog2(FIXED_REGS);

	logic [WORD_W-1:0] fixed_q [FIXED_REGS];
	logic              take;
	logic [SIZE_W-1:0] pm;
	logic [SIZE_W-1:0] am;
	logic [FIX_IW-1:0] fix_sel;
	logic [2:0]        fix_slot;
	logic [WORD_W-1:0] fix_word;
	beat_t             beat_d;
	beat_t             beat_s1;

	assign take = in_valid && adv;

	// Decode physical mask from the address width
	assign pm = (SIZE_W'(1) << phys_addr_bits) - SIZE_W'(1);
	assign am = pm & ~PAGE_OFFSET_MASK;

	// Pick fixed register and byte slot below 1 MB
	always_comb begin
		fix_sel  = '0;
		fix_slot = '0;
		priority if (lookup_address < FIX16_START) begin
			fix_sel  = '0;
			fix_slot = lookup_address[18:16];
		end else if (lookup_address < FIX16B_START) begin
			fix_sel  = FIX_IW'(1);
			fix_slot = lookup_address[16:14];
		end else if (lookup_address < FIX4_START) begin
			fix_sel  = FIX_IW'(2);
			fix_slot = lookup_address[16:14];
		end else begin
			fix_sel  = FIX_IW'(3) + FIX_IW'(lookup_address[17:15]);
			fix_slot = lookup_address[14:12];
		end
	end

	assign fix_word = fixed_q[fix_sel];

	// Build the beat
	always_comb begin
		beat_d        = '0;
		beat_d.idx    = entry_index;
		beat_d.addr   = lookup_address;
		beat_d.lookup = take && (opcode == OP_LOOKUP);
		beat_d.var_wr = take && (opcode == OP_VAR_WRITE);
		if (opcode == OP_LOOKUP) begin
			beat_d.hit   = lookup_address < ONE_MEG;
			beat_d.mtype = fix_word[{fix_slot, 3'b000} +: TYPE_W];
		end else if (mask_word[RANGE_VALID_BIT]) begin
			beat_d.wbase = base_word[31:12];
			beat_d.wsize = (~(mask_word[SIZE_W-1:0] & am) & pm) + SIZE_W'(1);
			beat_d.mtype = base_word[TYPE_W-1:0];
		end
	end

	// Advance the entry stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
		end else if (adv) begin
			beat_s1 <= beat_d;
		end
	end

	// Load fixed-range words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FIXED_REGS; i++) begin
				fixed_q[i] <= '0;
			end
		end else if (take && opcode == OP_FIX_WRITE && int'(entry_index) < FIXED_REGS) begin
			fixed_q[entry_index[FIX_IW-1:0]] <= base_word;
		end
	end

	assign beat_out = beat_s1;

endmodule

`default_nettype wire

// ----- src/mtrrl_cell.sv -----
`default_nettype none

module mtrrl_cell #(
	parameter int CELL_INDEX = 0
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       adv,
	input  wire mtrrl_pkg::beat_t beat_in,
	output mtrrl_pkg::beat_t beat_out
);
	import mtrrl_pkg::*;

	logic [BASE_W-1:0] base_q;
	logic [SIZE_W-1:0] size_q;
	logic [TYPE_W-1:0] type_q;
	logic [ADDR_W-1:0] base_addr;
	logic [ADDR_W-1:0] offset;
	logic              match;
	logic              wr_here;
	beat_t             fwd_d;
	beat_t             fwd_s1;

	// Compare address against this range
	assign base_addr = {base_q, 12'h000};
	assign offset    = beat_in.addr - base_addr;
	assign match     = (beat_in.addr >= base_addr)
		&& ({(SIZE_W - ADDR_W)'(0), offset} < size_q);

	assign wr_here = beat_in.var_wr && (int'(beat_in.idx) == CELL_INDEX);

	// Claim the lookup on first match
	always_comb begin
		fwd_d = beat_in;
		if (beat_in.lookup && !beat_in.hit && match) begin
			fwd_d.hit   = 1'b1;
			fwd_d.mtype = type_q;
		end
	end

	// Advance the beat to the neighbor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_s1 <= '0;
		end else if (adv) begin
			fwd_s1 <= fwd_d;
		end
	end

	// Load this range on a write beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= '0;
			type_q <= '0;
		end else if (adv && wr_here) begin
			base_q <= beat_in.wbase;
			size_q <= beat_in.wsize;
			type_q <= beat_in.mtype;
		end
	end

	assign beat_out = fwd_s1;

	a_size_page: assert property (@(posedge clk) disable iff (!arst_n)
		size_q == '0 || size_q[SIZE_W-1:12] != '0)
		else $error("range size below one page");

	a_empty_clear: assert property (@(posedge clk) disable iff (!arst_n)
		size_q == '0 |-> (base_q == '0 && type_q == '0))
		else $error("empty range holds stale base or type");

endmodule

`default_nettype wire

// ----- src/mtrr_memory_type_lookup.sv -----
// Memory type lookup over fixed and variable ranges.
// Input channel (in_valid / in_stall): one beat carries opcode, entry_index,
// base_word, mask_word and lookup_address. Lookups yield one memory_type beat
// on the output channel (out_valid / out_stall); range writes yield nothing.
// Config channel (cfg_valid / cfg_ready): cfg_data sets the physical address
// width, saturated to 32..52; cfg_ready is always high. Write it while idle.
// Beats flow through an entry stage that resolves addresses below 1 MB and
// decodes range writes, then through a row of VAR_RANGES cells, one range
// per cell; a lookup picks up the type of the first cell that matches.
// Path: a beat is registered in the entry stage, in each cell and in the output register.
// Throughput: one beat per cycle unless out_stall freezes the row; writes and
// lookups stay in order because they travel the same row.
// Stall: while a result waits under out_stall the whole row freezes and
// in_stall is raised; nothing is dropped.
// Reset: all ranges and fixed words clear to zero, the address width to 36.
`default_nettype none

module mtrr_memory_type_lookup #(
	parameter int VAR_RANGES = mtrrl_pkg::VAR_RANGES_DEF,
	parameter int FIXED_REGS = mtrrl_pkg::FIXED_REGS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [1:0]                    opcode,
	input  wire logic [mtrrl_pkg::ENTRY_W-1:0] entry_index,
	input  wire logic [mtrrl_pkg::WORD_W-1:0]  base_word,
	input  wire logic [mtrrl_pkg::WORD_W-1:0]  mask_word,
	input  wire logic [mtrrl_pkg::ADDR_W-1:0]  lookup_address,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [mtrrl_pkg::TYPE_W-1:0]       memory_type,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [mtrrl_pkg::PAB_W-1:0]   cfg_data
);
	import mtrrl_pkg::*;

	logic              adv;
	logic [PAB_W-1:0]  phys_q;
	logic              out_valid_q;
	logic [TYPE_W-1:0] memory_type_q;
	beat_t             chain [VAR_RANGES+1];

	// Freeze the row while a result waits
	assign adv       = !out_valid_q || !out_stall;
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;

	// Hold the address width, saturated
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phys_q <= PAB_RESET;
		end else if (cfg_valid) begin
			if (cfg_data < PAB_MIN) begin
				phys_q <= PAB_MIN;
			end else if (cfg_data > PAB_MAX) begin
				phys_q <= PAB_MAX;
			end else begin
				phys_q <= cfg_data;
			end
		end
	end

	mtrrl_entry #(
		.FIXED_REGS(FIXED_REGS)
	) u_entry (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.opcode        (opcode),
		.entry_index   (entry_index),
		.base_word     (base_word),
		.mask_word     (mask_word),
		.lookup_address(lookup_address),
		.phys_addr_bits(phys_q),
		.beat_out      (chain[0])
	);

	for (genvar g = 0; g < VAR_RANGES; g++) begin : g_cell
		mtrrl_cell #(
			.CELL_INDEX(g)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.beat_in (chain[g]),
			.beat_out(chain[g+1])
		);
	end

	// Drive the output register from the last cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= chain[VAR_RANGES].lookup;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			memory_type_q <= chain[VAR_RANGES].hit ? chain[VAR_RANGES].mtype
				: TYPE_WRITEBACK;
		end
	end

	assign out_valid   = out_valid_q;
	assign memory_type = memory_type_q;

	a_stall_backs_up: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input taken while result is stalled");

	a_pab_range: assert property (@(posedge clk) disable iff (!arst_n)
		phys_q >= PAB_MIN && phys_q <= PAB_MAX)
		else $error("address width out of range");

endmodule

`default_nettype wire
